// ----- design/gpi_pkg.sv -----
package gpi_pkg;

    localparam int ADDR_WIDTH      = 16;
    localparam int MESH_WIDTH      = 8;
    localparam int INDEX_WIDTH     = 24;
    localparam int CFG_INDEX_WIDTH = 2;

    // action codes
    localparam logic ACT_DOUBLED = 1'b0;
    localparam logic ACT_PLAIN   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MESH_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MESH_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MESH_Z = 2'd2;

    localparam logic [MESH_WIDTH-1:0] MESH_RESET = MESH_WIDTH'(1);

    typedef struct packed {
        logic                         action;
        logic signed [ADDR_WIDTH-1:0] address_x;
        logic signed [ADDR_WIDTH-1:0] address_y;
        logic signed [ADDR_WIDTH-1:0] address_z;
    } addr_item_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] grid_index;
        logic                   mesh_valid;
    } index_item_t;

endpackage

// ----- design/gpi_euclid_lane.sv -----
module gpi_euclid_lane
(
    input  logic                                    clk,
    input  logic                                    en,
    input  logic                                    action,
    input  logic signed [gpi_pkg::ADDR_WIDTH-1:0]   coord,
    input  logic        [gpi_pkg::MESH_WIDTH-1:0]   modulus,
    output logic        [gpi_pkg::MESH_WIDTH-1:0]   residue
);
    import gpi_pkg::*;

    localparam int W  = ADDR_WIDTH;
    localparam int MW = MESH_WIDTH;

    logic signed [W-1:0]  halved;
    logic        [W-1:0]  mag_next;
    logic        [W-1:0]  mag_reg [0:W-1];
    logic                 neg_reg [0:W];
    logic        [MW-1:0] rem_reg [0:W];
    logic        [MW-1:0] residue_reg;
    logic        [MW-1:0] residue_next;

    // halve doubled addresses (floor), then split into sign and magnitude
    assign halved   = (action == ACT_DOUBLED) ? (coord >>> 1) : coord;
    assign mag_next = halved[W-1] ? W'(-halved) : W'(halved);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= mag_next;
            neg_reg[0] <= halved[W-1];
            rem_reg[0] <= '0;
        end
    end

    // one magnitude bit per stage, MSB first: shift in, compare, subtract
    for (genvar k = 1; k <= W; k++)
    begin : g_rem
        logic [MW:0]   trial;
        logic [MW-1:0] rem_next;

        assign trial = {rem_reg[k-1], mag_reg[k-1][W-k]};

        always_comb
        begin
            if (trial >= {1'b0, modulus})
                rem_next = MW'(trial - {1'b0, modulus});
            else
                rem_next = MW'(trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                neg_reg[k] <= neg_reg[k-1];
            end
        end

        if (k < W)
        begin : g_mag
            always_ff @(posedge clk)
            begin
                if (en)
                    mag_reg[k] <= mag_reg[k-1];
            end
        end
    end

    // fold negative values back into 0 .. modulus-1
    assign residue_next = (neg_reg[W] && (rem_reg[W] != '0)) ? (modulus - rem_reg[W])
                                                              : rem_reg[W];

    always_ff @(posedge clk)
    begin
        if (en)
            residue_reg <= residue_next;
    end

    assign residue = residue_reg;

endmodule

// ----- design/gpi_index_mac.sv -----
module gpi_index_mac
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [gpi_pkg::MESH_WIDTH-1:0]      rx,
    input  logic [gpi_pkg::MESH_WIDTH-1:0]      ry,
    input  logic [gpi_pkg::MESH_WIDTH-1:0]      rz,
    input  logic [gpi_pkg::MESH_WIDTH-1:0]      mx,
    input  logic [gpi_pkg::MESH_WIDTH-1:0]      my,
    input  logic                                mesh_ok,
    output gpi_pkg::index_item_t                result
);
    import gpi_pkg::*;

    localparam int MW  = MESH_WIDTH;
    localparam int PW2 = 2 * MW;
    localparam int PW3 = 3 * MW;

    logic [PW2-1:0]         py_reg;
    logic [PW2-1:0]         pxy_reg;
    logic [MW-1:0]          rx1_reg;
    logic [MW-1:0]          rz1_reg;
    logic [PW3-1:0]         zprod;
    logic [INDEX_WIDTH-1:0] zterm_reg;
    logic [INDEX_WIDTH-1:0] sum1_reg;
    index_item_t            result_reg;
    index_item_t            result_next;

    // stage 1: y*mx and mx*my
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            py_reg  <= PW2'(ry) * PW2'(mx);
            pxy_reg <= PW2'(mx) * PW2'(my);
            rx1_reg <= rx;
            rz1_reg <= rz;
        end
    end

    // stage 2: z*mx*my and x + y*mx
    assign zprod = PW3'(rz1_reg) * PW3'(pxy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zterm_reg <= INDEX_WIDTH'(zprod);
            sum1_reg  <= INDEX_WIDTH'(rx1_reg) + INDEX_WIDTH'(py_reg);
        end
    end

    // stage 3: final add, force zero on an invalid mesh
    always_comb
    begin
        result_next.mesh_valid = mesh_ok;
        result_next.grid_index = mesh_ok ? (sum1_reg + zterm_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- design/grid_point_index_from_address.sv -----
// Channel   Direction  Handshake                  Payload
// addr      in         addr_valid / addr_stall    addr_item_t  (action, address_x/y/z)
// index     out        index_valid / index_stall  index_item_t (grid_index, mesh_valid)
// cfg       in         cfg_we                     cfg_index, cfg_data (mesh_x/y/z)
//
// Throughput: one transfer per cycle on each side while index is not stalled.
// The remainder chain retires one magnitude bit per stage in each of the three axis lanes.
// Reset clears the valid line and loads mesh sizes of 1; the datapath is not reset.
// A stall on index with a result waiting freezes the whole pipeline and stalls addr;
// bubbles are carried along, nothing is dropped or repeated.
module grid_point_index_from_address
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    addr_valid,
    output logic                                    addr_stall,
    input  gpi_pkg::addr_item_t                     addr,
    output logic                                    index_valid,
    input  logic                                    index_stall,
    output gpi_pkg::index_item_t                    index,
    input  logic                                    cfg_we,
    input  logic [gpi_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [gpi_pkg::MESH_WIDTH-1:0]          cfg_data
);
    import gpi_pkg::*;

    // lane: capture + ADDR_WIDTH remainder stages + fold; then three mac stages
    localparam int LAT = ADDR_WIDTH + 5;

    logic [MESH_WIDTH-1:0] mesh_x_reg;
    logic [MESH_WIDTH-1:0] mesh_y_reg;
    logic [MESH_WIDTH-1:0] mesh_z_reg;
    logic [LAT-1:0]        valid_reg;
    logic [LAT-1:0]        valid_next;
    logic                  en;
    logic                  mesh_ok;
    logic [MESH_WIDTH-1:0] res_x;
    logic [MESH_WIDTH-1:0] res_y;
    logic [MESH_WIDTH-1:0] res_z;

    // Configuration registers; indexes past mesh_z are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_x_reg <= MESH_RESET;
            mesh_y_reg <= MESH_RESET;
            mesh_z_reg <= MESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MESH_X: mesh_x_reg <= cfg_data;
                REG_MESH_Y: mesh_y_reg <= cfg_data;
                REG_MESH_Z: mesh_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign mesh_ok = (mesh_x_reg != '0) && (mesh_y_reg != '0) && (mesh_z_reg != '0);

    // Advance everything unless a finished result is held by the consumer.
    assign en         = !(valid_reg[LAT-1] && index_stall);
    assign addr_stall = !en;

    // Valid bits ride alongside the datapath stages.
    assign valid_next = {valid_reg[LAT-2:0], addr_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // Three Euclidean-modulo lanes, one per axis.
    gpi_euclid_lane u_lane_x
    (
        .clk     (clk),
        .en      (en),
        .action  (addr.action),
        .coord   (addr.address_x),
        .modulus (mesh_x_reg),
        .residue (res_x)
    );

    gpi_euclid_lane u_lane_y
    (
        .clk     (clk),
        .en      (en),
        .action  (addr.action),
        .coord   (addr.address_y),
        .modulus (mesh_y_reg),
        .residue (res_y)
    );

    gpi_euclid_lane u_lane_z
    (
        .clk     (clk),
        .en      (en),
        .action  (addr.action),
        .coord   (addr.address_z),
        .modulus (mesh_z_reg),
        .residue (res_z)
    );

    // Combine the residues into the linear index, x fastest.
    gpi_index_mac u_mac
    (
        .clk     (clk),
        .en      (en),
        .rx      (res_x),
        .ry      (res_y),
        .rz      (res_z),
        .mx      (mesh_x_reg),
        .my      (mesh_y_reg),
        .mesh_ok (mesh_ok),
        .result  (index)
    );

    assign index_valid = valid_reg[LAT-1];

    // An accepted transfer always lands in the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (addr_valid && !addr_stall) |=> valid_reg[0])
        else $error("accepted address did not enter the pipeline");

    // A held result freezes the valid line.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("valid line moved while stalled");

    // An invalid mesh always yields index zero.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (index_valid && !index.mesh_valid) |-> (index.grid_index == '0))
        else $error("nonzero index on invalid mesh");

endmodule
